// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define GCD_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("great circle distance assertion failed");

// Concurrent assertion on the block clock and reset.
`define GCD_ASSERT(label, prop) `GCD_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

// ----- rtl/gcd_pkg.sv -----
// ----------------------------------------------------------------------------
// Great circle distance package
// Types, fixed-point constants and the arctangent table shared by the cells
// and the top level.
// ----------------------------------------------------------------------------
package gcd_pkg;

  // Working width of angles, sines and cosines (signed Q30 plus headroom).
  localparam int CW = 34;
  typedef logic signed [CW-1:0] cw_t;

  localparam int QF = 30;
  localparam cw_t Q30_ONE  = 34'sd1073741824;
  localparam cw_t PI       = 34'sd3373259422;
  localparam cw_t TWO_PI   = 34'sd6746518844;
  localparam cw_t HALF_PI  = 34'sd1686629711;
  localparam cw_t INV_GAIN = 34'sd652032874;

  // pi/180 in Q32.
  localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961320;
  localparam int DEG_PROD_W = 59;

  localparam int DIST_W   = 26;
  localparam int RADIUS_W = 24;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6531246;
  localparam int THETA_W  = 33;
  localparam int DPROD_W  = THETA_W + RADIUS_W;

  // Square root of a Q60 radicand: one root bit per cell.
  localparam int SQRT_STEPS = 31;
  localparam int ROOT_W     = 31;
  localparam int RADIC_W    = 2 * SQRT_STEPS;
  localparam int REM_W      = ROOT_W + 1;

  // Register map: byte address bit 2 selects the register.
  localparam int APB_ADDR_W = 3;
  localparam logic REG_SPHERE_RADIUS = 1'b0;

  // atan(2^-i) in Q30, rounded down.
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
    32'd127, 32'd63, 32'd31, 32'd15, 32'd7, 32'd3, 32'd1, 32'd0, 32'd0
  };

  typedef struct packed {
    logic signed [31:0] first_latitude;
    logic signed [31:0] first_longitude;
    logic signed [31:0] second_latitude;
    logic signed [31:0] second_longitude;
  } gcd_req_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              first_invalid;
    logic              second_invalid;
  } gcd_rsp_t;

endpackage

// ----- rtl/gcd_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// CORDIC cell
// One micro-rotation for a group of lanes, rotation or vectoring mode, with a
// registered output and a sideband that travels along with the lanes.
// ----------------------------------------------------------------------------
module gcd_cordic_cell import gcd_pkg::*; #(
  parameter int STAGE  = 0,
  parameter bit VECTOR = 1'b0,
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  cw_t [LANES-1:0]       x_i,
  input  cw_t [LANES-1:0]       y_i,
  input  cw_t [LANES-1:0]       z_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  vld_o,
  output cw_t [LANES-1:0]       x_o,
  output cw_t [LANES-1:0]       y_o,
  output cw_t [LANES-1:0]       z_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam cw_t ATAN = cw_t'(ATAN_Q30[STAGE]);

  cw_t [LANES-1:0]   x_d, y_d, z_d;
  cw_t [LANES-1:0]   x_q, y_q, z_q;
  logic [SIDE_W-1:0] side_q;
  logic              vld_q;

  always_comb begin
    cw_t xl, yl, zl, dx, dy;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    for (int l = 0; l < LANES; l++) begin
      xl = x_i[l];
      yl = y_i[l];
      zl = z_i[l];
      dx = yl >>> STAGE;
      dy = xl >>> STAGE;
      // Vectoring drives y toward zero, rotation drives z toward zero.
      if (VECTOR ? !yl[CW-1] : zl[CW-1]) begin
        x_d[l] = xl + dx;
        y_d[l] = yl - dy;
        z_d[l] = zl + ATAN;
      end else begin
        x_d[l] = xl - dx;
        y_d[l] = yl + dy;
        z_d[l] = zl - ATAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign side_o = side_q;

endmodule

// ----- rtl/gcd_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// Square root cell
// One step of the digit-by-digit integer square root: takes two radicand
// bits and settles one root bit, registered, with a sideband.
// ----------------------------------------------------------------------------
module gcd_sqrt_cell import gcd_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [RADIC_W-1:0] v_i,
  input  logic [REM_W-1:0]   rem_i,
  input  logic [ROOT_W-1:0]  root_i,
  input  logic [SIDE_W-1:0]  side_i,
  output logic               vld_o,
  output logic [RADIC_W-1:0] v_o,
  output logic [REM_W-1:0]   rem_o,
  output logic [ROOT_W-1:0]  root_o,
  output logic [SIDE_W-1:0]  side_o
);

  logic [REM_W+1:0]   rem_wide, trial;
  logic [RADIC_W-1:0] v_d, v_q;
  logic [REM_W-1:0]   rem_d, rem_q;
  logic [ROOT_W-1:0]  root_d, root_q;
  logic [SIDE_W-1:0]  side_q;
  logic               vld_q;

  always_comb begin
    rem_wide = {rem_i, v_i[RADIC_W-1 -: 2]};
    trial    = {1'b0, root_i, 2'b01};
    v_d      = {v_i[RADIC_W-3:0], 2'b00};
    if (rem_wide >= trial) begin
      rem_d  = REM_W'(rem_wide - trial);
      root_d = {root_i[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_wide[REM_W-1:0];
      root_d = {root_i[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q    <= v_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign v_o    = v_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign side_o = side_q;

endmodule

// ----- rtl/great_circle_distance_unit.sv -----
// ----------------------------------------------------------------------------
// Great circle distance unit
// Spherical law of cosines over two points given in fixed-point degrees.
// ----------------------------------------------------------------------------
// Requests arrive on in_req_i (valid/ready) as two latitude/longitude pairs
// in 2^-ANGLE_FRAC_BITS degree; one response per request leaves on
// out_rsp_o (valid/ready) with the distance and a flag per point that had a
// coordinate out of range; that coordinate is zeroed.
// The datapath is one pipeline: input check and degree conversion (6
// stages), a chain of CORDIC_STAGES rotation cells for the three cosines
// and sines, products, clamp and radicand (5 stages), a 31-cell square root
// chain, a chain of CORDIC_STAGES vectoring cells for the arccosine, and
// three stages for the radius scaling and output register.
// A new request is taken every cycle while the pipeline does not halt.
// The whole pipeline advances together; it halts only while a response sits
// in the output register and the receiver holds out_ready_i low, and
// in_ready_o falls for that time.
// Reset empties the pipeline and sets sphere_radius to 6378.17 km. The
// radius is written over the APB port at byte address 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module great_circle_distance_unit import gcd_pkg::*; #(
  parameter int CORDIC_STAGES   = 24,
  parameter int ANGLE_FRAC_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  gcd_req_t              in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output gcd_rsp_t              out_rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam cw_t LAT_BOUND = cw_t'(longint'(90) << ANGLE_FRAC_BITS);
  localparam cw_t LON_BOUND = cw_t'(longint'(180) << ANGLE_FRAC_BITS);
  localparam logic [DEG_PROD_W-1:0] DEG_RND =
    DEG_PROD_W'(1) << (ANGLE_FRAC_BITS + 1);
  localparam int NROT = CORDIC_STAGES;

  // ---------------- configuration ----------------
  logic [RADIUS_W-1:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_SPHERE_RADIUS) begin
      radius_q <= pwdata[RADIUS_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SPHERE_RADIUS) ? 32'(radius_q) : '0;

  // ---------------- pipeline control ----------------
  logic en;
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q;
  logic v6_q, v7_q, v8_q, v9_q, v10_q, v11_q, v12_q, out_vld_q;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // ---------------- stage 0: range check ----------------
  logic signed [31:0] c_in [4];
  logic signed [31:0] c_chk [4];
  logic               bad_in [4];
  logic signed [31:0] c0_q [4];
  logic               bad1_0_q, bad2_0_q;

  always_comb begin
    cw_t e;
    c_in[0] = in_req_i.first_latitude;
    c_in[1] = in_req_i.first_longitude;
    c_in[2] = in_req_i.second_latitude;
    c_in[3] = in_req_i.second_longitude;
    for (int k = 0; k < 4; k++) begin
      e = cw_t'(c_in[k]);
      if (k % 2 == 0) begin
        bad_in[k] = (e < -LAT_BOUND) || (e > LAT_BOUND);
      end else begin
        bad_in[k] = (e < -LON_BOUND) || (e > LON_BOUND);
      end
      c_chk[k] = bad_in[k] ? '0 : c_in[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_q     <= c_chk;
      bad1_0_q <= bad_in[0] || bad_in[1];
      bad2_0_q <= bad_in[2] || bad_in[3];
    end
  end

  // ---------------- stage 1: degree to radian product ----------------
  logic [DEG_PROD_W-1:0] prod1_q [4];
  logic                  sgn1_q [4];
  logic                  bad1_1_q, bad2_1_q;

  always_ff @(posedge clk_i) begin
    logic [31:0] mag;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        mag        = c0_q[k][31] ? 32'(-c0_q[k]) : 32'(c0_q[k]);
        prod1_q[k] <= DEG_PROD_W'(mag) * DEG_PROD_W'(DEG_TO_RAD_Q32);
        sgn1_q[k]  <= c0_q[k][31];
      end
      bad1_1_q <= bad1_0_q;
      bad2_1_q <= bad2_0_q;
    end
  end

  // ---------------- stage 2: round and sign ----------------
  cw_t  rad2_q [4];
  logic bad1_2_q, bad2_2_q;

  always_ff @(posedge clk_i) begin
    cw_t r;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        r          = cw_t'((prod1_q[k] + DEG_RND) >> (ANGLE_FRAC_BITS + 2));
        rad2_q[k] <= sgn1_q[k] ? -r : r;
      end
      bad1_2_q <= bad1_1_q;
      bad2_2_q <= bad2_1_q;
    end
  end

  // ---------------- stages 3 to 5: longitude difference folding ----------------
  cw_t  lat1_3_q, lat2_3_q, diff3_q;
  cw_t  lat1_4_q, lat2_4_q, a4_q;
  cw_t  lat1_5_q, lat2_5_q, a5_q;
  logic neg5_q;
  logic bad1_3_q, bad2_3_q, bad1_4_q, bad2_4_q, bad1_5_q, bad2_5_q;

  always_ff @(posedge clk_i) begin
    cw_t ab, a;
    if (en) begin
      lat1_3_q <= rad2_q[0];
      lat2_3_q <= rad2_q[2];
      diff3_q  <= rad2_q[3] - rad2_q[1];
      bad1_3_q <= bad1_2_q;
      bad2_3_q <= bad2_2_q;

      // Evenness and 2*pi periodicity bring the difference into [0, pi].
      ab       = diff3_q[CW-1] ? -diff3_q : diff3_q;
      a4_q     <= (ab > PI) ? TWO_PI - ab : ab;
      lat1_4_q <= lat1_3_q;
      lat2_4_q <= lat2_3_q;
      bad1_4_q <= bad1_3_q;
      bad2_4_q <= bad2_3_q;

      // cos(x) = -cos(pi - x) keeps the CORDIC input within [0, pi/2].
      a = a4_q[CW-1] ? '0 : a4_q;
      if (a > HALF_PI) begin
        neg5_q <= 1'b1;
        a5_q   <= PI - a;
      end else begin
        neg5_q <= 1'b0;
        a5_q   <= a;
      end
      lat1_5_q <= lat1_4_q;
      lat2_5_q <= lat2_4_q;
      bad1_5_q <= bad1_4_q;
      bad2_5_q <= bad2_4_q;
    end
  end

  // ---------------- rotation chain: lanes lat1, lat2, longitude ----------------
  cw_t [2:0]  rx [NROT+1];
  cw_t [2:0]  ry [NROT+1];
  cw_t [2:0]  rz [NROT+1];
  logic [2:0] rs [NROT+1];
  logic       rv [NROT+1];

  assign rx[0] = {INV_GAIN, INV_GAIN, INV_GAIN};
  assign ry[0] = '0;
  assign rz[0] = {a5_q, lat2_5_q, lat1_5_q};
  assign rs[0] = {neg5_q, bad1_5_q, bad2_5_q};
  assign rv[0] = v5_q;

  for (genvar g = 0; g < NROT; g++) begin : g_rot
    gcd_cordic_cell #(
      .STAGE (g),
      .VECTOR(1'b0),
      .LANES (3),
      .SIDE_W(3)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (rv[g]),
      .x_i   (rx[g]),
      .y_i   (ry[g]),
      .z_i   (rz[g]),
      .side_i(rs[g]),
      .vld_o (rv[g+1]),
      .x_o   (rx[g+1]),
      .y_o   (ry[g+1]),
      .z_o   (rz[g+1]),
      .side_o(rs[g+1])
    );
  end

  // Stages 6 to 10: cosine law products, clamp and radicand
  cw_t  rot_c1, rot_s1, rot_c2, rot_s2, rot_cd;
  logic rot_neg, rot_bad1, rot_bad2;

  assign rot_c1   = rx[NROT][0];
  assign rot_s1   = ry[NROT][0];
  assign rot_c2   = rx[NROT][1];
  assign rot_s2   = ry[NROT][1];
  assign rot_cd   = rx[NROT][2];
  assign rot_neg  = rs[NROT][2];
  assign rot_bad1 = rs[NROT][1];
  assign rot_bad2 = rs[NROT][0];

  cw_t                  m1_6_q, m2_6_q, cdn6_q, m1_7_q, m3_7_q;
  logic [ROOT_W-1:0]    absarg8_q, absarg9_q, absarg10_q;
  logic                 argneg8_q, argneg9_q, argneg10_q;
  logic [RADIC_W-2:0]   sq9_q;
  logic [RADIC_W-1:0]   radic10_q;
  logic bad1_6_q, bad2_6_q, bad1_7_q, bad2_7_q, bad1_8_q, bad2_8_q;
  logic bad1_9_q, bad2_9_q, bad1_10_q, bad2_10_q;

  always_ff @(posedge clk_i) begin
    logic signed [63:0] p1, p2, p3;
    cw_t                arg;
    if (en) begin
      p1       = 32'(rot_s1) * 32'(rot_s2);
      p2       = 32'(rot_c1) * 32'(rot_c2);
      m1_6_q   <= cw_t'(p1 >>> QF);
      m2_6_q   <= cw_t'(p2 >>> QF);
      cdn6_q   <= rot_neg ? -rot_cd : rot_cd;
      bad1_6_q <= rot_bad1;
      bad2_6_q <= rot_bad2;

      p3       = 32'(m2_6_q) * 32'(cdn6_q);
      m3_7_q   <= cw_t'(p3 >>> QF);
      m1_7_q   <= m1_6_q;
      bad1_7_q <= bad1_6_q;
      bad2_7_q <= bad2_6_q;

      // Clamp the arccosine argument to [-1, 1] against rounding.
      arg = m1_7_q + m3_7_q;
      if (arg > Q30_ONE) begin
        arg = Q30_ONE;
      end else if (arg < -Q30_ONE) begin
        arg = -Q30_ONE;
      end
      argneg8_q <= arg[CW-1];
      absarg8_q <= ROOT_W'(arg[CW-1] ? -arg : arg);
      bad1_8_q  <= bad1_7_q;
      bad2_8_q  <= bad2_7_q;

      sq9_q     <= (RADIC_W-1)'(RADIC_W'(absarg8_q) * RADIC_W'(absarg8_q));
      absarg9_q <= absarg8_q;
      argneg9_q <= argneg8_q;
      bad1_9_q  <= bad1_8_q;
      bad2_9_q  <= bad2_8_q;

      radic10_q  <= (RADIC_W'(1) << (2 * QF)) - RADIC_W'(sq9_q);
      absarg10_q <= absarg9_q;
      argneg10_q <= argneg9_q;
      bad1_10_q  <= bad1_9_q;
      bad2_10_q  <= bad2_9_q;
    end
  end

  // ---------------- square root chain ----------------
  localparam int SQ_SIDE_W = ROOT_W + 3;

  logic [RADIC_W-1:0]   sv_v [SQRT_STEPS+1];
  logic [REM_W-1:0]     sv_rem [SQRT_STEPS+1];
  logic [ROOT_W-1:0]    sv_root [SQRT_STEPS+1];
  logic [SQ_SIDE_W-1:0] sv_side [SQRT_STEPS+1];
  logic                 sv_vld [SQRT_STEPS+1];

  assign sv_v[0]    = radic10_q;
  assign sv_rem[0]  = '0;
  assign sv_root[0] = '0;
  assign sv_side[0] = {absarg10_q, argneg10_q, bad1_10_q, bad2_10_q};
  assign sv_vld[0]  = v10_q;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    gcd_sqrt_cell #(
      .SIDE_W(SQ_SIDE_W)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (sv_vld[g]),
      .v_i   (sv_v[g]),
      .rem_i (sv_rem[g]),
      .root_i(sv_root[g]),
      .side_i(sv_side[g]),
      .vld_o (sv_vld[g+1]),
      .v_o   (sv_v[g+1]),
      .rem_o (sv_rem[g+1]),
      .root_o(sv_root[g+1]),
      .side_o(sv_side[g+1])
    );
  end

  // ---------------- vectoring chain: arccosine ----------------
  cw_t [0:0]  vx [NROT+1];
  cw_t [0:0]  vy [NROT+1];
  cw_t [0:0]  vz [NROT+1];
  logic [2:0] vs [NROT+1];
  logic       vv [NROT+1];

  assign vx[0] = cw_t'({1'b0, sv_side[SQRT_STEPS][SQ_SIDE_W-1 -: ROOT_W]});
  assign vy[0] = cw_t'({1'b0, sv_root[SQRT_STEPS]});
  assign vz[0] = '0;
  assign vs[0] = sv_side[SQRT_STEPS][2:0];
  assign vv[0] = sv_vld[SQRT_STEPS];

  for (genvar g = 0; g < NROT; g++) begin : g_vec
    gcd_cordic_cell #(
      .STAGE (g),
      .VECTOR(1'b1),
      .LANES (1),
      .SIDE_W(3)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (vv[g]),
      .x_i   (vx[g]),
      .y_i   (vy[g]),
      .z_i   (vz[g]),
      .side_i(vs[g]),
      .vld_o (vv[g+1]),
      .x_o   (vx[g+1]),
      .y_o   (vy[g+1]),
      .z_o   (vz[g+1]),
      .side_o(vs[g+1])
    );
  end

  // ---------------- stages 11 to 13: angle, radius, output ----------------
  logic [THETA_W-1:0] theta11_q;
  logic [DPROD_W-1:0] dprod12_q;
  logic               bad1_11_q, bad2_11_q, bad1_12_q, bad2_12_q;
  gcd_rsp_t           out_rsp_q;

  always_ff @(posedge clk_i) begin
    cw_t                th, vz_out;
    logic [DPROD_W-1:0] sum;
    logic [DPROD_W-1:0] dist_full;
    if (en) begin
      vz_out = vz[NROT][0];
      th     = vs[NROT][2] ? PI - vz_out : vz_out;
      theta11_q <= th[CW-1] ? '0 : THETA_W'(th);
      bad1_11_q <= vs[NROT][1];
      bad2_11_q <= vs[NROT][0];

      dprod12_q <= DPROD_W'(theta11_q) * DPROD_W'(radius_q);
      bad1_12_q <= bad1_11_q;
      bad2_12_q <= bad2_11_q;

      sum       = dprod12_q + (DPROD_W'(1) << (QF - 1));
      dist_full = sum >> QF;
      out_rsp_q.distance       <= (dist_full > DPROD_W'({DIST_W{1'b1}}))
                                  ? {DIST_W{1'b1}} : DIST_W'(dist_full);
      out_rsp_q.first_invalid  <= bad1_12_q;
      out_rsp_q.second_invalid <= bad2_12_q;
    end
  end

  // ---------------- valid pipeline ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q      <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      v6_q      <= 1'b0;
      v7_q      <= 1'b0;
      v8_q      <= 1'b0;
      v9_q      <= 1'b0;
      v10_q     <= 1'b0;
      v11_q     <= 1'b0;
      v12_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      v0_q      <= in_valid_i;
      v1_q      <= v0_q;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      v6_q      <= rv[NROT];
      v7_q      <= v6_q;
      v8_q      <= v7_q;
      v9_q      <= v8_q;
      v10_q     <= v9_q;
      v11_q     <= vv[NROT];
      v12_q     <= v11_q;
      out_vld_q <= v12_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_rsp_q;

  // ---------------- assertions ----------------
  `GCD_ASSERT(a_stall_freezes_pipe,
    !en |=> $stable(v0_q) && $stable(v5_q) && $stable(v10_q) && $stable(v12_q))
  `GCD_ASSERT(a_fold_in_quadrant,
    v5_q |-> !a5_q[CW-1] && (a5_q <= HALF_PI))
  `GCD_ASSERT(a_root_bounded,
    sv_vld[SQRT_STEPS] |-> sv_root[SQRT_STEPS] <= ROOT_W'(Q30_ONE))

endmodule
